>>> rtl/cdg_pkg.sv
// ----------------------------------------------------------------------------
// Cross-to-dot grid interpolation package
// Shared register indexes, field widths and the position flag bundle.
// ----------------------------------------------------------------------------
package cdg_pkg;

   localparam int ROWS_W     = 16;
   localparam int COLS_W     = 11;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS = 1'd1;

   // where the current request sits on the grid border
   typedef struct packed {
      logic top_row;
      logic bottom_row;
      logic first_col;
      logic last_col;
   } pos_flags_type;

endpackage

>>> rtl/cdg_line_buf.sv
// ----------------------------------------------------------------------------
// Line buffer
// One row of samples; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdg_line_buf #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cdg_avg.sv
// ----------------------------------------------------------------------------
// Four-point average
// Sums the 1, 2 or 4 samples picked by the border flags and floors the mean.
// ----------------------------------------------------------------------------
module cdg_avg #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic signed [SAMPLE_BITS-1:0] cur,
   input  logic signed [SAMPLE_BITS-1:0] left,
   input  logic signed [SAMPLE_BITS-1:0] up,
   input  logic signed [SAMPLE_BITS-1:0] up_left,
   input  cdg_pkg::pos_flags_type        flags,
   output logic signed [SAMPLE_BITS-1:0] avg
);

   import cdg_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + 2;

   logic use_cur_row, use_prev_row, use_cur_col, use_prev_col;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] shifted;
   logic [1:0] sh;

   always_comb begin
      use_cur_row  = !flags.bottom_row;
      use_prev_row = !flags.top_row;
      use_cur_col  = !flags.last_col;
      use_prev_col = !flags.first_col;

      sum = '0;
      if (use_cur_row && use_cur_col)   sum = sum + SUM_W'(cur);
      if (use_cur_row && use_prev_col)  sum = sum + SUM_W'(left);
      if (use_prev_row && use_cur_col)  sum = sum + SUM_W'(up);
      if (use_prev_row && use_prev_col) sum = sum + SUM_W'(up_left);

      sh = {1'b0, use_cur_row && use_prev_row} + {1'b0, use_cur_col && use_prev_col};
      // arithmetic shift rounds toward minus infinity
      shifted = sum >>> sh;
      avg     = shifted[SAMPLE_BITS-1:0];
   end

endmodule

>>> rtl/cross_to_dot_grid_interpolation.sv
// ----------------------------------------------------------------------------
// Cross-to-dot grid interpolation
// Streams raster-order cross samples and returns one dot value per sample.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle and its result appears in the
// output register on the next cycle; the block keeps accepting while that
// result waits as long as the consumer takes it in the same cycle. The rate
// is set by the line buffer, which is written once per request and read one
// column ahead, so the sample above is ready when its request arrives. The
// line buffer needs no clearing after reset. Program num_rows and num_cols
// (csr index 0 and 1) only while no request is in flight; tlast on the
// result marks the last position of the grid.
module cross_to_dot_grid_interpolation #(
   parameter int MAX_COLS    = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [cdg_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [cdg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // [SB-1:0] sample
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,  // [SB-1:0] dot_value
   output logic                                 rsp_tlast   // frame_end
);

   import cdg_pkg::*;

   localparam int DW    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CW    = $clog2(MAX_COLS);
   localparam int CNT_W = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

   logic [ROWS_W-1:0] num_rows_ff;
   logic [COLS_W-1:0] num_cols_ff;
   logic [ROWS_W-1:0] row_index_ff, row_index_in;
   logic [CW-1:0]     col_index_ff, col_index_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, up_left_ff;
   logic signed [SAMPLE_BITS-1:0] dot_ff;
   logic              last_ff;
   logic              rsp_valid_ff;

   logic [ROWS_W-1:0] rows_m1;
   logic [CNT_W-1:0]  cols_ext, cols_lim, cols_m1;
   pos_flags_type     flags;
   logic              accept;
   logic signed [SAMPLE_BITS-1:0] cur, up, avg;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign cur        = req_tdata[SAMPLE_BITS-1:0];

   // effective grid size
   always_comb begin
      rows_m1  = (num_rows_ff < ROWS_W'(2)) ? ROWS_W'(1) : num_rows_ff - ROWS_W'(1);
      cols_ext = CNT_W'(num_cols_ff);
      if (cols_ext < CNT_W'(2)) begin
         cols_lim = CNT_W'(2);
      end else if (cols_ext > CNT_W'(MAX_COLS)) begin
         cols_lim = CNT_W'(MAX_COLS);
      end else begin
         cols_lim = cols_ext;
      end
      cols_m1 = cols_lim - CNT_W'(1);
   end

   always_comb begin
      flags.top_row    = (row_index_ff == '0);
      flags.bottom_row = (row_index_ff >= rows_m1);
      flags.first_col  = (col_index_ff == '0);
      flags.last_col   = (CNT_W'(col_index_ff) >= cols_m1);

      if (flags.last_col) begin
         col_index_in = '0;
         row_index_in = flags.bottom_row ? '0 : row_index_ff + ROWS_W'(1);
      end else begin
         col_index_in = col_index_ff + CW'(1);
         row_index_in = row_index_ff;
      end
   end

   // read one column ahead so the upper sample is ready on the next request
   cdg_line_buf #(
      .DEPTH (MAX_COLS),
      .WIDTH (SAMPLE_BITS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_index_ff),
      .wr_data (cur),
      .rd_en   (accept),
      .rd_addr (col_index_in),
      .rd_data (up)
   );

   cdg_avg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_avg (
      .cur     (cur),
      .left    (left_ff),
      .up      (up),
      .up_left (up_left_ff),
      .flags   (flags),
      .avg     (avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROWS_W'(2);
         num_cols_ff <= COLS_W'(2);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata[ROWS_W-1:0];
            CSR_NUM_COLS: num_cols_ff <= csr_wdata[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff <= '0;
         col_index_ff <= '0;
         left_ff      <= '0;
         up_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_index_ff <= row_index_in;
            col_index_ff <= col_index_in;
            left_ff      <= cur;
            up_left_ff   <= up;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dot_ff  <= avg;
         last_ff <= flags.bottom_row && flags.last_col;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'(unsigned'(dot_ff));
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/cdg_checker.sv
// ----------------------------------------------------------------------------
// Cross-to-dot grid interpolation checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module cdg_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // every accepted request yields a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no result");

   // an empty output register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // no result is valid right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind cross_to_dot_grid_interpolation cdg_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_cdg_checker (.*);
